@@ rtl/mkd_pkg.sv @@
// Shared types, constants and the dot-length bound function for the Morse keying decoder.
// No dependencies.
package mkd_pkg;

  localparam int DOT_W    = 16;
  localparam int HOLD_W   = 8;
  localparam int CODE_W   = 22;
  localparam int BOUND_W  = 19;
  localparam int HC_W     = 9;
  localparam int CFG_A_W  = 1;
  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = 2;
  localparam int Q_CNT_W  = 3;

  localparam logic [CFG_A_W-1:0] REG_DOT_LENGTH = 1'd0;
  localparam logic [CFG_A_W-1:0] REG_HOLD_OFF   = 1'd1;

  localparam logic [DOT_W-1:0]  DOT_RESET  = 16'd9390;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd64;

  localparam logic [1:0] DIGIT_NONE = 2'd0;
  localparam logic [1:0] DIGIT_DOT  = 2'd1;
  localparam logic [1:0] DIGIT_DASH = 2'd3;

  typedef enum logic [1:0] {
    EV_ELEM,
    EV_LETTER,
    EV_WORD,
    EV_FLUSH
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [1:0] digit;
  } event_t;

  typedef struct packed {
    logic [BOUND_W-1:0] dot_lo;
    logic [BOUND_W-1:0] dot_hi;
    logic [BOUND_W-1:0] dash_lo;
    logic [BOUND_W-1:0] dash_hi;
    logic [BOUND_W-1:0] word_lo;
  } bounds_t;

  // 3d/4, 5d/4, 5d/2, 7d/2, 6d by shift-add
  function automatic bounds_t calc_bounds(input logic [DOT_W-1:0] d);
    logic [BOUND_W-1:0] dx;
    logic [BOUND_W-1:0] d3;
    logic [BOUND_W-1:0] d5;
    logic [BOUND_W-1:0] d7;
    bounds_t b;
    dx        = BOUND_W'(d);
    d3        = (dx << 1) + dx;
    d5        = (dx << 2) + dx;
    d7        = (dx << 3) - dx;
    b.dot_lo  = d3 >> 2;
    b.dot_hi  = d5 >> 2;
    b.dash_lo = d5 >> 1;
    b.dash_hi = d7 >> 1;
    b.word_lo = d3 << 1;
    return b;
  endfunction

endpackage

@@ rtl/morse_keying_decoder.sv @@
// Morse keying decoder: one key sample or flush per transfer, letters and word spaces out.
// An input's result passes through the event queue, then the result register; a word space
// follows its letter. One input per cycle while the queue is not full; one result per cycle
// while out_tready allows, so a word gap (two results) is absorbed by a four-entry event queue.
// Reset (synchronous, rst_n low): dot_length 9390, hold_off 64, timing and letter state
// cleared, queue and result register empty.
module morse_keying_decoder
  import mkd_pkg::*;
#(
  parameter int MAX_ELEMENTS = 7,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [DOT_W-1:0]   cfg_wdata,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [0] key_bit, [7:1] zero
  input  logic               in_tuser,   // [0] flush
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [23:0]        out_tdata,  // [21:0] letter_code, [22] letter_invalid, [23] zero
  output logic               out_tuser,  // [0] symbol_kind
  output logic               out_tlast
);

  logic              accept;
  logic              ev_push;
  event_t            ev, q_head;
  logic              q_empty, q_full, q_pop;
  logic [CODE_W-1:0] code;
  logic              bad;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  mkd_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .accept   (accept),
    .key_bit  (in_tdata[0]),
    .flush    (in_tuser),
    .ev_push  (ev_push),
    .ev       (ev)
  );

  mkd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (ev_push),
    .push_ev(ev),
    .pop    (q_pop),
    .head   (q_head),
    .empty  (q_empty),
    .full   (q_full)
  );

  mkd_back #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_kind (out_tuser),
    .out_code (code),
    .out_bad  (bad),
    .out_last (out_tlast)
  );

  assign out_tdata = {1'b0, bad, code};

endmodule

@@ rtl/mkd_front.sv @@
// Front end: config registers, key timing state and mark/gap classification.
// Depends on mkd_pkg; pushes events into mkd_queue.
module mkd_front
  import mkd_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [DOT_W-1:0]   cfg_wdata,
  input  logic               accept,
  input  logic               key_bit,
  input  logic               flush,
  output logic               ev_push,
  output event_t             ev
);

  localparam int CW    = COUNT_WIDTH;
  localparam int CMP_W = (CW > BOUND_W) ? CW : BOUND_W;

  bounds_t             bnd_r;
  logic [HOLD_W-1:0]   hold_off_r;
  logic                prev_bit_r, prev_bit_nxt;
  logic signed [HC_W-1:0] hc_r, hc_nxt, hc_dec, reload;
  logic                in_mark_r, in_mark_nxt;
  logic [CW-1:0]       sample_count_r, sample_count_nxt;
  logic [CW-1:0]       mark_start_r, mark_start_nxt;
  logic [CW-1:0]       last_end_r, last_end_nxt;
  logic                have_prev_r, have_prev_nxt;
  logic [CW-1:0]       pos, gap, len;
  logic [CMP_W-1:0]    gap_x, len_x;
  logic                len_dot, len_dash, gap_letter, gap_word;

  function automatic logic in_rng(input logic [CMP_W-1:0] v,
                                  input logic [BOUND_W-1:0] lo,
                                  input logic [BOUND_W-1:0] hi);
    return (v >= CMP_W'(lo)) && (v <= CMP_W'(hi));
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bnd_r      <= calc_bounds(DOT_RESET);
      hold_off_r <= HOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DOT_LENGTH: bnd_r      <= calc_bounds(cfg_wdata);
        REG_HOLD_OFF:   hold_off_r <= cfg_wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign pos    = sample_count_r + {{(CW-1){1'b0}}, 1'b1};
  assign gap    = pos - last_end_r;
  assign len    = pos - mark_start_r;
  assign gap_x  = CMP_W'(gap);
  assign len_x  = CMP_W'(len);
  assign reload = $signed({1'b0, (hold_off_r == '0) ? HOLD_W'(1) : hold_off_r});
  assign hc_dec = (hc_r == -9'sd1) ? hc_r : hc_r - 9'sd1;

  assign len_dot    = in_rng(len_x, bnd_r.dot_lo, bnd_r.dot_hi);
  assign len_dash   = in_rng(len_x, bnd_r.dash_lo, bnd_r.dash_hi);
  assign gap_letter = in_rng(gap_x, bnd_r.dash_lo, bnd_r.dash_hi);
  assign gap_word   = gap_x >= CMP_W'(bnd_r.word_lo);

  always_comb begin
    prev_bit_nxt     = prev_bit_r;
    hc_nxt           = hc_r;
    in_mark_nxt      = in_mark_r;
    sample_count_nxt = sample_count_r;
    mark_start_nxt   = mark_start_r;
    last_end_nxt     = last_end_r;
    have_prev_nxt    = have_prev_r;
    ev_push          = 1'b0;
    ev.kind          = EV_ELEM;
    ev.digit         = DIGIT_NONE;
    if (accept) begin
      if (flush) begin
        ev_push       = 1'b1;
        ev.kind       = EV_FLUSH;
        have_prev_nxt = 1'b0;
      end else begin
        hc_nxt           = hc_dec;
        prev_bit_nxt     = key_bit;
        sample_count_nxt = pos;
        if (!in_mark_r && hc_dec[HC_W-1] && !prev_bit_r && key_bit) begin
          if (have_prev_r) begin
            if (gap_letter) begin
              ev_push = 1'b1;
              ev.kind = EV_LETTER;
            end else if (gap_word) begin
              ev_push = 1'b1;
              ev.kind = EV_WORD;
            end
          end
          mark_start_nxt = pos;
          hc_nxt         = reload;
          in_mark_nxt    = 1'b1;
        end else if (hc_dec > 9'sd0 && key_bit) begin
          hc_nxt = reload;
        end else if (hc_dec == 9'sd0 && in_mark_r) begin
          last_end_nxt  = pos;
          in_mark_nxt   = 1'b0;
          have_prev_nxt = 1'b1;
          ev_push       = 1'b1;
          ev.kind       = EV_ELEM;
          ev.digit      = len_dot ? DIGIT_DOT : (len_dash ? DIGIT_DASH : DIGIT_NONE);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_bit_r     <= 1'b0;
      hc_r           <= -9'sd1;
      in_mark_r      <= 1'b0;
      sample_count_r <= '0;
      mark_start_r   <= '0;
      last_end_r     <= '0;
      have_prev_r    <= 1'b0;
    end else begin
      prev_bit_r     <= prev_bit_nxt;
      hc_r           <= hc_nxt;
      in_mark_r      <= in_mark_nxt;
      sample_count_r <= sample_count_nxt;
      mark_start_r   <= mark_start_nxt;
      last_end_r     <= last_end_nxt;
      have_prev_r    <= have_prev_nxt;
    end
  end

endmodule

@@ rtl/mkd_queue.sv @@
// Short event queue between the front and back ends.
// Depends on mkd_pkg.
module mkd_queue
  import mkd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  event_t push_ev,
  input  logic   pop,
  output event_t head,
  output logic   empty,
  output logic   full
);

  event_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;
  logic                 do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
    end
  end

endmodule

@@ rtl/mkd_back.sv @@
// Back end: letter assembly from queued events and the registered result stage.
// Depends on mkd_pkg; reads events from mkd_queue.
module mkd_back
  import mkd_pkg::*;
#(
  parameter int MAX_ELEMENTS = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  event_t            q_head,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [CODE_W-1:0] out_code,
  output logic              out_bad,
  output logic              out_last
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  logic [CODE_W-1:0] digits_r, digits_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              bad_r, bad_nxt;
  logic              space_pend_r, space_pend_nxt;
  logic              valid_r, valid_nxt;
  logic              kind_r, kind_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              obad_r, obad_nxt;
  logic              last_r, last_nxt;
  logic              can_load;

  assign can_load = !valid_r || out_ready;

  always_comb begin
    digits_nxt     = digits_r;
    count_nxt      = count_r;
    bad_nxt        = bad_r;
    space_pend_nxt = space_pend_r;
    valid_nxt      = valid_r;
    kind_nxt       = kind_r;
    code_nxt       = code_r;
    obad_nxt       = obad_r;
    last_nxt       = last_r;
    q_pop          = 1'b0;
    if (can_load) valid_nxt = 1'b0;
    if (can_load && space_pend_r) begin
      valid_nxt      = 1'b1;
      kind_nxt       = 1'b1;
      code_nxt       = '0;
      obad_nxt       = 1'b0;
      last_nxt       = 1'b1;
      space_pend_nxt = 1'b0;
    end else if (can_load && !q_empty) begin
      q_pop = 1'b1;
      unique case (q_head.kind)
        EV_ELEM: begin
          if (q_head.digit == DIGIT_NONE || count_r >= CNT_W'(MAX_ELEMENTS)) begin
            bad_nxt = 1'b1;
          end else begin
            digits_nxt = (digits_r << 3) + (digits_r << 1) + CODE_W'(q_head.digit);
            count_nxt  = count_r + 1'b1;
          end
        end
        EV_LETTER, EV_WORD, EV_FLUSH: begin
          if (q_head.kind != EV_FLUSH || count_r != '0 || bad_r) begin
            valid_nxt  = 1'b1;
            kind_nxt   = 1'b0;
            code_nxt   = digits_r;
            obad_nxt   = bad_r;
            last_nxt   = (q_head.kind != EV_WORD);
            digits_nxt = '0;
            count_nxt  = '0;
            bad_nxt    = 1'b0;
            space_pend_nxt = (q_head.kind == EV_WORD);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r     <= '0;
      count_r      <= '0;
      bad_r        <= 1'b0;
      space_pend_r <= 1'b0;
      valid_r      <= 1'b0;
    end else begin
      digits_r     <= digits_nxt;
      count_r      <= count_nxt;
      bad_r        <= bad_nxt;
      space_pend_r <= space_pend_nxt;
      valid_r      <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    code_r <= code_nxt;
    obad_r <= obad_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_code  = code_r;
  assign out_bad   = obad_r;
  assign out_last  = last_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ELEMENTS))
    else $error("element count above limit");

  a_space_follows_letter: assert property (@(posedge clk) disable iff (!rst_n)
    space_pend_r |-> (valid_r && !kind_r && !last_r))
    else $error("word space pending without held letter");

  a_space_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && kind_r) |-> (code_r == '0 && !obad_r && last_r))
    else $error("word space result carries letter data");

endmodule

@@ tb/sv/morse_keying_decoder_test.sv @@
// Self-checking testbench for morse_keying_decoder: directed key sequences, then random
// letters (some with junk elements), noise and flushes under several register settings and idle patterns.
// Depends on mkd_pkg and the decoder RTL.
module morse_keying_decoder_test;
  import mkd_pkg::*;

  localparam int MAX_LETTER_ELEMENTS = 7;
  localparam int STALL_LIMIT         = 2000;
  localparam int SETTLE_CYCLES       = 8;

  typedef struct packed {
    logic              kind;
    logic [CODE_W-1:0] code;
    logic              bad;
    logic              last;
  } symbol_t;

  typedef enum bit [1:0] {
    BY_MODEL,
    NO_SYMBOL,
    ONE_SYMBOL
  } row_check_e;

  typedef struct packed {
    bit         flush;
    bit         key;
    bit [7:0]   reps;
    row_check_e check;
    symbol_t    want;
  } key_row_t;

  typedef enum int {
    ELEM_DOT,
    ELEM_DASH,
    ELEM_JUNK
  } elem_kind_e;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr = REG_DOT_LENGTH;
  logic [DOT_W-1:0]   cfg_wdata = '0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata = '0;   // [0] key_bit, [7:1] zero
  logic               in_tuser = 1'b0; // [0] flush
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [23:0]        out_tdata;       // [21:0] letter_code, [22] letter_invalid, [23] zero
  logic               out_tuser;       // [0] symbol_kind
  logic               out_tlast;

  morse_keying_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // predictor state and register copy
  bit [DOT_W-1:0]  dot_len        = DOT_RESET;
  bit [HOLD_W-1:0] hold_reg       = HOLD_RESET;
  bit              prev_bit       = 1'b0;
  int              holdoff_cnt    = -1;
  bit              in_mark        = 1'b0;
  bit [31:0]       sample_count   = '0;
  bit [31:0]       mark_start     = '0;
  bit [31:0]       last_mark_end  = '0;
  bit              have_prev_mark = 1'b0;
  bit [CODE_W-1:0] letter_digits  = '0;
  int              element_count  = 0;
  bit              letter_bad     = 1'b0;

  symbol_t     pending_symbols [$];
  int unsigned items_sent     = 0;
  int unsigned symbols_seen   = 0;
  int unsigned mismatch_count = 0;
  int          quiet_cycles   = 0;
  int          send_idle_pct  = 0;
  int          recv_idle_pct  = 0;

  key_row_t directed_rows [15] = '{
    '{1'b1, 1'b1, 8'd1,  NO_SYMBOL,  '0},                      // flush, nothing pending
    '{1'b0, 1'b1, 8'd1,  BY_MODEL,   '0},                      // dot
    '{1'b0, 1'b0, 8'd2,  BY_MODEL,   '0},
    '{1'b0, 1'b1, 8'd4,  BY_MODEL,   '0},                      // dash
    '{1'b0, 1'b0, 8'd6,  BY_MODEL,   '0},                      // letter gap
    '{1'b0, 1'b1, 8'd1,  ONE_SYMBOL, '{1'b0, 22'd13, 1'b0, 1'b1}},
    '{1'b0, 1'b1, 8'd1,  BY_MODEL,   '0},                      // mark between dot and dash
    '{1'b0, 1'b0, 8'd2,  BY_MODEL,   '0},
    '{1'b1, 1'b0, 8'd1,  ONE_SYMBOL, '{1'b0, 22'd0, 1'b1, 1'b1}},
    '{1'b0, 1'b1, 8'd1,  BY_MODEL,   '0},                      // fresh letter after flush
    '{1'b0, 1'b0, 8'd13, BY_MODEL,   '0},                      // word gap
    '{1'b0, 1'b1, 8'd1,  BY_MODEL,   '0},
    '{1'b0, 1'b0, 8'd2,  BY_MODEL,   '0},
    '{1'b1, 1'b0, 8'd1,  ONE_SYMBOL, '{1'b0, 22'd1, 1'b0, 1'b1}},
    '{1'b1, 1'b0, 8'd1,  NO_SYMBOL,  '0}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void clear_letter();
    letter_digits = '0;
    element_count = 0;
    letter_bad    = 1'b0;
  endfunction

  function automatic int decode_key_sample(input bit key, input bit flush,
                                           output symbol_t s0, output symbol_t s1);
    int              n;
    int              reload;
    int              digit;
    longint unsigned d;
    bit [31:0]       pos;
    bit [31:0]       gap;
    bit [31:0]       len;
    symbol_t         letter;
    symbol_t         space;
    n      = 0;
    s0     = '0;
    s1     = '0;
    d      = dot_len;
    reload = (hold_reg == 0) ? 1 : int'(hold_reg);
    letter = '{kind: 1'b0, code: letter_digits, bad: letter_bad, last: 1'b0};
    space  = '{kind: 1'b1, code: '0, bad: 1'b0, last: 1'b0};
    if (flush) begin
      if (element_count != 0 || letter_bad) begin
        s0 = letter;
        n  = 1;
        clear_letter();
      end
      have_prev_mark = 1'b0;
    end else begin
      pos = sample_count + 32'd1;
      if (holdoff_cnt > -1) holdoff_cnt--;
      if (!in_mark && holdoff_cnt < 0 && !prev_bit && key) begin
        if (have_prev_mark) begin
          gap = pos - last_mark_end;
          if (gap >= 5 * d / 2 && gap <= 7 * d / 2) begin
            s0 = letter;
            n  = 1;
            clear_letter();
          end else if (gap >= 6 * d) begin
            s0 = letter;
            s1 = space;
            n  = 2;
            clear_letter();
          end
        end
        mark_start  = pos;
        holdoff_cnt = reload;
        in_mark     = 1'b1;
      end else if (holdoff_cnt > 0 && key) begin
        holdoff_cnt = reload;
      end else if (holdoff_cnt == 0 && in_mark) begin
        last_mark_end  = pos;
        in_mark        = 1'b0;
        have_prev_mark = 1'b1;
        len            = pos - mark_start;
        digit          = 0;
        if (len >= 3 * d / 4 && len <= 5 * d / 4) digit = 1;
        else if (len >= 5 * d / 2 && len <= 7 * d / 2) digit = 3;
        if (digit == 0 || element_count >= MAX_LETTER_ELEMENTS) begin
          letter_bad = 1'b1;
        end else begin
          letter_digits = CODE_W'(32'(letter_digits) * 10 + digit);
          element_count++;
        end
      end
      prev_bit     = key;
      sample_count = pos;
    end
    if (n == 1) s0.last = 1'b1;
    else if (n == 2) s1.last = 1'b1;
    return n;
  endfunction

  task automatic note_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatch_count++;
    $display("mismatch at symbol %0d: %s got %0d want %0d", symbols_seen, what, got, want);
  endtask

  task automatic take_symbol();
    symbol_t want;
    if (pending_symbols.size() == 0) begin
      note_mismatch("unexpected symbol, code", out_tdata[CODE_W-1:0], 0);
    end else begin
      want = pending_symbols.pop_front();
      if (out_tuser !== want.kind) note_mismatch("symbol_kind", out_tuser, want.kind);
      if (out_tdata[CODE_W-1:0] !== want.code)
        note_mismatch("letter_code", out_tdata[CODE_W-1:0], want.code);
      if (out_tdata[CODE_W] !== want.bad)
        note_mismatch("letter_invalid", out_tdata[CODE_W], want.bad);
      if (out_tlast !== want.last) note_mismatch("last", out_tlast, want.last);
    end
    symbols_seen++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) take_symbol();
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("morse_keying_decoder_test: FAIL");
    $finish;
  end

  task automatic send_item(bit key, bit flush, row_check_e check, symbol_t want);
    symbol_t r0;
    symbol_t r1;
    int      n;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, key};
    in_tuser  <= flush;
    do @(posedge clk); while (in_tready !== 1'b1);
    n = decode_key_sample(key, flush, r0, r1);
    case (check)
      BY_MODEL: begin
        if (n > 0) pending_symbols.push_back(r0);
        if (n > 1) pending_symbols.push_back(r1);
      end
      ONE_SYMBOL: pending_symbols.push_back(want);
      default: ;
    endcase
    items_sent++;
  endtask

  task automatic send_level(bit key, int count);
    repeat (count) send_item(key, 1'b0, BY_MODEL, '0);
  endtask

  // wait out every expected symbol, then let the pipeline settle
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(bit [DOT_W-1:0] d_word, bit [DOT_W-1:0] h_word);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_DOT_LENGTH;
    cfg_wdata <= d_word;
    @(posedge clk);
    cfg_addr  <= REG_HOLD_OFF;
    cfg_wdata <= h_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
    dot_len  = d_word;
    hold_reg = h_word[HOLD_W-1:0];
  endtask

  task automatic send_noise();
    repeat ($urandom_range(24, 4))
      send_item($urandom_range(1, 0), $urandom_range(19, 0) == 0, BY_MODEL, '0);
  endtask

  // one letter: marks sized for dot/dash windows or junk lengths, inner gaps, then a letter or word gap
  task automatic send_letter(int max_el);
    int         d;
    int         h;
    int         n_el;
    int         len;
    int         gap;
    int         sel;
    int         lo;
    int         hi;
    elem_kind_e kind;
    d    = dot_len;
    h    = (hold_reg == 0) ? 1 : int'(hold_reg);
    n_el = ($urandom_range(9, 0) == 0) ? $urandom_range(max_el, 1) : $urandom_range(5, 1);
    if (n_el > max_el) n_el = max_el;
    for (int i = 0; i < n_el; i++) begin
      sel  = $urandom_range(99, 0);
      kind = (sel < 45) ? ELEM_DOT : (sel < 90) ? ELEM_DASH : ELEM_JUNK;
      case (kind)
        ELEM_DOT:  len = $urandom_range(5 * d / 4, 3 * d / 4);
        ELEM_DASH: len = $urandom_range(7 * d / 2, 5 * d / 2);
        default:   len = $urandom_range(4 * d + 2, 1);
      endcase
      if (len < 1) len = 1;
      send_level(1'b1, (len >= h) ? len - h + 1 : 1);
      sel = $urandom_range(99, 0);
      if (i < n_el - 1) begin
        lo = 7 * d / 2 + 1;
        hi = 6 * d - 1;
        if (sel >= 85 && hi >= lo) gap = $urandom_range(hi, lo);
        else gap = $urandom_range((5 * d / 2 > 1) ? 5 * d / 2 - 1 : 1, 1);
      end else if (sel < 75) begin
        gap = $urandom_range(7 * d / 2, 5 * d / 2);
      end else begin
        gap = $urandom_range(8 * d + 1, 6 * d);
      end
      if (gap < 1) gap = 1;
      send_level(1'b0, gap + h - 1);
    end
  endtask

  task automatic run_phase(bit [DOT_W-1:0] d_word, bit [DOT_W-1:0] h_word, int budget,
                           int max_el, bit noise_only);
    int unsigned first;
    int          sel;
    quiesce();
    program_regs(d_word, h_word);
    first = items_sent;
    while (items_sent - first < budget) begin
      sel = $urandom_range(99, 0);
      if (noise_only ? (sel < 90) : (sel < 8)) send_noise();
      else if (noise_only || sel < 14) send_item($urandom_range(1, 0), 1'b1, BY_MODEL, '0);
      else send_letter(max_el);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 15;
    recv_idle_pct = 67;
    program_regs(16'd2, 16'd2);
    foreach (directed_rows[i]) begin
      for (int k = 0; k < directed_rows[i].reps; k++)
        send_item(directed_rows[i].key, directed_rows[i].flush,
                  (k == directed_rows[i].reps - 1) ? directed_rows[i].check : BY_MODEL,
                  directed_rows[i].want);
    end

    run_phase(16'd2, 16'd2, 120, 9, 1'b0);
    run_phase(16'd0, 16'd3, 80, 9, 1'b0);
    run_phase(16'd65535, 16'd1, 80, 9, 1'b1);

    send_idle_pct = 67;
    recv_idle_pct = 15;
    run_phase(16'd3, 16'd0, 90, 9, 1'b0);
    run_phase(16'd80, 16'd255, 1, 3, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(16'd1, 16'd1, 90, 9, 1'b0);
    run_phase(16'd5, 16'hAB03, 90, 9, 1'b0);
    run_phase(16'd4, 16'd2, 90, 9, 1'b0);

    quiesce();
    if (mismatch_count == 0) begin
      $display("morse_keying_decoder_test: PASS");
    end else begin
      $display("morse_keying_decoder_test: FAIL");
    end
    $finish;
  end

endmodule
